// ----- rtl/coau_pkg.sv -----
// ----------------------------------------------------------------------------
// coau_pkg
// Shared types and codes for the operand address unit.
// ----------------------------------------------------------------------------
package coau_pkg;

  typedef enum logic [3:0] {
    MODE_ACC = 4'd0,
    MODE_IMP = 4'd1,
    MODE_IMM = 4'd2,
    MODE_ZP0 = 4'd3,
    MODE_ZPX = 4'd4,
    MODE_ZPY = 4'd5,
    MODE_ABS = 4'd6,
    MODE_ABX = 4'd7,
    MODE_ABY = 4'd8,
    MODE_REL = 4'd9,
    MODE_IND = 4'd10,
    MODE_IZX = 4'd11,
    MODE_IZY = 4'd12
  } mode_e;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  localparam logic [15:0] PAGE_MASK = 16'hFF00;
  localparam logic [7:0]  SIGN_BIT  = 8'h80;

  typedef struct packed {
    logic        busy;
    logic [3:0]  mode_held;
    logic [1:0]  phase;
    logic [15:0] pc_held;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [15:0] pointer_word;
    logic [7:0]  low_byte;
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  mode;
    logic [15:0] pc_in;
    logic [7:0]  reg_a;
    logic [7:0]  reg_x;
    logic [7:0]  reg_y;
    logic [7:0]  read_data;
  } beat_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] read_addr;
    logic [15:0] addr_abs;
    logic [15:0] addr_rel;
    logic [7:0]  fetched;
    logic [15:0] new_pc;
    logic        extra_cycle;
  } result_t;

endpackage

// ----- rtl/coau_if.sv -----
// ----------------------------------------------------------------------------
// coau_if
// Valid/ready channels for the request and result beats.
// ----------------------------------------------------------------------------
interface coau_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  mode;
  logic [15:0] pc_in;
  logic [7:0]  reg_a;
  logic [7:0]  reg_x;
  logic [7:0]  reg_y;
  logic [7:0]  read_data;

  modport source (
    output valid, req_type, mode, pc_in, reg_a, reg_x, reg_y, read_data,
    input  ready
  );
  modport sink (
    input  valid, req_type, mode, pc_in, reg_a, reg_x, reg_y, read_data,
    output ready
  );
endinterface

interface coau_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] read_addr;
  logic [15:0] addr_abs;
  logic [15:0] addr_rel;
  logic [7:0]  fetched;
  logic [15:0] new_pc;
  logic        extra_cycle;

  modport source (
    output valid, kind, read_addr, addr_abs, addr_rel, fetched, new_pc, extra_cycle,
    input  ready
  );
  modport sink (
    input  valid, kind, read_addr, addr_abs, addr_rel, fetched, new_pc, extra_cycle,
    output ready
  );
endinterface

// ----- rtl/coau_step.sv -----
// ----------------------------------------------------------------------------
// coau_step
// Next-state and result logic for one accepted beat.
// ----------------------------------------------------------------------------
module coau_step
  import coau_pkg::*;
(
  input  state_t  st_i,
  input  beat_t   beat_i,
  output state_t  st_o,
  output logic    emit_o,
  output result_t res_o
);

  logic [15:0] pc1;
  logic [15:0] pc2;
  logic [15:0] base;
  logic [15:0] idx_addr;
  logic [7:0]  idx;
  logic [7:0]  d;

  assign d    = beat_i.read_data;
  assign pc1  = st_i.pc_held + 16'd1;
  assign pc2  = st_i.pc_held + 16'd2;
  assign base = {d, st_i.low_byte};
  assign idx  = (mode_e'(st_i.mode_held) == MODE_ABX) ? st_i.index_x : st_i.index_y;
  assign idx_addr = base + {8'h00, idx};

  always_comb begin
    st_o   = st_i;
    emit_o = 1'b0;
    res_o  = '0;
    if (beat_i.req_type == REQ_START) begin
      if (!st_i.busy) begin
        emit_o = 1'b1;
        res_o.kind = KIND_DONE;
        case (mode_e'(beat_i.mode)) inside
          MODE_ACC, MODE_IMP: begin
            res_o.fetched = beat_i.reg_a;
            res_o.new_pc  = beat_i.pc_in;
          end
          MODE_IMM: begin
            res_o.addr_abs = beat_i.pc_in;
            res_o.new_pc   = beat_i.pc_in + 16'd1;
          end
          [MODE_ZP0:MODE_IZY]: begin
            st_o.busy         = 1'b1;
            st_o.mode_held    = beat_i.mode;
            st_o.phase        = PH_0;
            st_o.pc_held      = beat_i.pc_in;
            st_o.index_x      = beat_i.reg_x;
            st_o.index_y      = beat_i.reg_y;
            st_o.pointer_word = '0;
            st_o.low_byte     = '0;
            res_o.kind        = KIND_READ;
            res_o.read_addr   = beat_i.pc_in;
          end
          default: begin
            res_o.new_pc = beat_i.pc_in;
          end
        endcase
      end
    end else if (st_i.busy) begin
      emit_o = 1'b1;
      res_o.kind = KIND_DONE;
      case (mode_e'(st_i.mode_held))
        MODE_ZP0: begin
          res_o.addr_abs = {8'h00, d};
          res_o.new_pc   = pc1;
        end
        MODE_ZPX: begin
          res_o.addr_abs = {8'h00, d + st_i.index_x};
          res_o.new_pc   = pc1;
        end
        MODE_ZPY: begin
          res_o.addr_abs = {8'h00, d + st_i.index_y};
          res_o.new_pc   = pc1;
        end
        MODE_REL: begin
          res_o.addr_rel = ((d & SIGN_BIT) != 8'h00) ? ({8'h00, d} | PAGE_MASK)
                                                      : {8'h00, d};
          res_o.new_pc   = pc1;
        end
        MODE_ABS, MODE_ABX, MODE_ABY: begin
          if (st_i.phase == PH_0) begin
            st_o.low_byte   = d;
            st_o.phase      = PH_1;
            res_o.kind      = KIND_READ;
            res_o.read_addr = pc1;
          end else begin
            res_o.new_pc = pc2;
            if (mode_e'(st_i.mode_held) == MODE_ABS) begin
              res_o.addr_abs = base;
            end else begin
              res_o.addr_abs    = idx_addr;
              res_o.extra_cycle = (idx_addr & PAGE_MASK) != (base & PAGE_MASK);
            end
          end
        end
        MODE_IND: begin
          case (st_i.phase)
            PH_0: begin
              st_o.low_byte   = d;
              st_o.phase      = PH_1;
              res_o.kind      = KIND_READ;
              res_o.read_addr = pc1;
            end
            PH_1: begin
              st_o.pointer_word = base;
              st_o.phase        = PH_2;
              res_o.kind        = KIND_READ;
              res_o.read_addr   = base;
            end
            PH_2: begin
              st_o.low_byte = d;
              st_o.phase    = PH_3;
              res_o.kind    = KIND_READ;
              // page-wrap bug: high byte comes from the start of the same page
              if (st_i.pointer_word[7:0] == 8'hFF) begin
                res_o.read_addr = st_i.pointer_word & PAGE_MASK;
              end else begin
                res_o.read_addr = st_i.pointer_word + 16'd1;
              end
            end
            default: begin
              res_o.addr_abs = base;
              res_o.new_pc   = pc2;
            end
          endcase
        end
        MODE_IZX, MODE_IZY: begin
          case (st_i.phase)
            PH_0: begin
              st_o.pointer_word = {8'h00, d};
              st_o.phase        = PH_1;
              res_o.kind        = KIND_READ;
              res_o.read_addr   = (mode_e'(st_i.mode_held) == MODE_IZX)
                                  ? {8'h00, d + st_i.index_x} : {8'h00, d};
            end
            PH_1: begin
              st_o.low_byte   = d;
              st_o.phase      = PH_2;
              res_o.kind      = KIND_READ;
              res_o.read_addr = (mode_e'(st_i.mode_held) == MODE_IZX)
                ? {8'h00, st_i.pointer_word[7:0] + st_i.index_x + 8'd1}
                : {8'h00, st_i.pointer_word[7:0] + 8'd1};
            end
            default: begin
              res_o.new_pc = pc1;
              if (mode_e'(st_i.mode_held) == MODE_IZX) begin
                res_o.addr_abs = base;
              end else begin
                res_o.addr_abs    = idx_addr;
                res_o.extra_cycle = (idx_addr & PAGE_MASK) != (base & PAGE_MASK);
              end
            end
          endcase
        end
        default: begin
          emit_o = 1'b0;
        end
      endcase
      if (emit_o && res_o.kind == KIND_DONE) begin
        st_o.busy  = 1'b0;
        st_o.phase = PH_0;
      end
    end
  end

endmodule

// ----- rtl/cpu_operand_address_unit.sv -----
// ----------------------------------------------------------------------------
// cpu_operand_address_unit
// Effective-address sequencer for the 8-bit CPU addressing modes.
// ----------------------------------------------------------------------------
// result: registered in the output register when an accepted beat emits one
// throughput: one beat per cycle while the output is ready, set by the single result register stage
// a new beat is taken while the held result is being taken downstream
// reset: asynchronous, clears the sequencer state and the output valid
module cpu_operand_address_unit
  import coau_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  coau_in_if.sink   in_i,
  coau_out_if.source out_o
);

  state_t  st_q, st_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    emit;
  logic    in_accept;
  beat_t   beat;

  assign beat = '{req_type:  in_i.req_type,
                  mode:      in_i.mode,
                  pc_in:     in_i.pc_in,
                  reg_a:     in_i.reg_a,
                  reg_x:     in_i.reg_x,
                  reg_y:     in_i.reg_y,
                  read_data: in_i.read_data};

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  coau_step u_step (
    .st_i   (st_q),
    .beat_i (beat),
    .st_o   (st_d),
    .emit_o (emit),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = res_q.kind;
  assign out_o.read_addr   = res_q.read_addr;
  assign out_o.addr_abs    = res_q.addr_abs;
  assign out_o.addr_rel    = res_q.addr_rel;
  assign out_o.fetched     = res_q.fetched;
  assign out_o.new_pc      = res_q.new_pc;
  assign out_o.extra_cycle = res_q.extra_cycle;

  a_done_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && emit && res_d.kind == KIND_DONE) |=> !st_q.busy)
    else $error("done beat left sequencer busy");

  a_phase_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase != PH_0) |-> st_q.busy)
    else $error("nonzero phase while idle");

  a_start_busy_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_i.req_type == REQ_START && st_q.busy) |=> st_q == $past(st_q))
    else $error("start while busy changed state");

  a_request_keeps_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && emit && res_d.kind == KIND_READ) |=> st_q.busy)
    else $error("read request issued without busy sequencer");

endmodule
